// ===== rtl/vcrp_pkg.sv =====
package vcrp_pkg;

    typedef enum logic [1:0] {
        MODE_REG_WRITE  = 2'd0,
        MODE_REG_READ   = 2'd1,
        MODE_MEM_RETURN = 2'd2,
        MODE_EVENT      = 2'd3
    } vcrp_mode_t;

    typedef enum logic [2:0] {
        REG_CTRL1       = 3'd0,
        REG_CTRL2       = 3'd1,
        REG_STATUS      = 3'd2,
        REG_SPRITE_ADDR = 3'd3,
        REG_SPRITE_DATA = 3'd4,
        REG_SCROLL      = 3'd5,
        REG_ADDR        = 3'd6,
        REG_DATA        = 3'd7
    } vcrp_reg_t;

    typedef enum logic [1:0] {
        EVT_VBLANK_START = 2'd0,
        EVT_VBLANK_END   = 2'd1,
        EVT_SPRITE_HIT   = 2'd2,
        EVT_OVERFLOW     = 2'd3
    } vcrp_event_t;

    localparam int STAT_VBLANK_BIT   = 7;
    localparam int STAT_HIT_BIT      = 6;
    localparam int STAT_OVERFLOW_BIT = 5;
    localparam int CTRL1_STEP_BIT    = 2;
    localparam int CTRL1_NMI_BIT     = 7;

    localparam logic [15:0] TEMP_NT_KEEP_MASK     = 16'hf3ff;
    localparam logic [15:0] TEMP_COARSE_KEEP_MASK = 16'hffe0;
    localparam logic [15:0] TEMP_SCROLL2_KEEP     = 16'h0c1f;
    localparam logic [7:0]  ADDR_HI_MASK          = 8'h3f;
    localparam logic [7:0]  SCROLL_COARSE_MASK    = 8'hf8;
    localparam logic [15:0] TEMP_HI_BYTE_MASK     = 16'hff00;
    localparam logic [15:0] STEP_ACROSS           = 16'd32;
    localparam logic [15:0] STEP_DOWN             = 16'd1;

    typedef struct packed {
        vcrp_mode_t  mode;
        vcrp_reg_t   reg_index;
        logic [7:0]  write_data;
        logic [7:0]  mem_return_data;
        vcrp_event_t event_code;
    } vcrp_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] mem_addr;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic        mem_read_request;
        logic [7:0]  sprite_mem_addr;
        logic [7:0]  sprite_mem_data;
        logic        sprite_mem_write;
        logic        interrupt_request;
    } vcrp_result_t;

endpackage

// ===== rtl/vcrp_in_reg.sv =====
module vcrp_in_reg
    import vcrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  vcrp_item_t up_item,
    output logic       dn_valid,
    input  logic       dn_ready,
    output vcrp_item_t dn_item
);

    logic       valid_reg;
    vcrp_item_t item_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up_item;
        end
    end

endmodule

// ===== rtl/vcrp_regs.sv =====
module vcrp_regs
    import vcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  vcrp_item_t   item,
    output vcrp_result_t result
);

    logic [7:0]  control_one_reg, control_one_next;
    logic [7:0]  control_two_reg, control_two_next;
    logic [7:0]  status_flags_reg, status_flags_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [15:0] temp_addr_reg, temp_addr_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  read_buf_reg, read_buf_next;

    logic [15:0] step;
    logic [7:0]  wd;

    assign step = control_one_reg[CTRL1_STEP_BIT] ? STEP_ACROSS : STEP_DOWN;
    assign wd   = item.write_data;

    always_comb
    begin
        control_one_next  = control_one_reg;
        control_two_next  = control_two_reg;
        status_flags_next = status_flags_reg;
        sprite_addr_next  = sprite_addr_reg;
        temp_addr_next    = temp_addr_reg;
        cur_addr_next     = cur_addr_reg;
        fine_x_next       = fine_x_reg;
        toggle_next       = toggle_reg;
        read_buf_next     = read_buf_reg;
        result            = '0;
        case (item.mode)
            MODE_REG_WRITE:
            begin
                case (item.reg_index)
                    REG_CTRL1:
                    begin
                        temp_addr_next = (temp_addr_reg & TEMP_NT_KEEP_MASK)
                            | {4'd0, wd[1:0], 10'd0};
                        control_one_next = wd;
                    end
                    REG_CTRL2:
                    begin
                        control_two_next = wd;
                    end
                    REG_SPRITE_ADDR:
                    begin
                        sprite_addr_next = wd;
                    end
                    REG_SPRITE_DATA:
                    begin
                        result.sprite_mem_addr  = sprite_addr_reg;
                        result.sprite_mem_data  = wd;
                        result.sprite_mem_write = 1'b1;
                        sprite_addr_next        = sprite_addr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            temp_addr_next = (temp_addr_reg & TEMP_COARSE_KEEP_MASK)
                                | {11'd0, wd[7:3]};
                            fine_x_next = wd[2:0];
                        end
                        else
                        begin
                            temp_addr_next = (temp_addr_reg & TEMP_SCROLL2_KEEP)
                                | {1'b0, wd[2:0], 12'd0}
                                | {6'd0, (wd & SCROLL_COARSE_MASK), 2'd0};
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            temp_addr_next = {(wd & ADDR_HI_MASK), temp_addr_reg[7:0]};
                        end
                        else
                        begin
                            temp_addr_next = (temp_addr_reg & TEMP_HI_BYTE_MASK)
                                | {8'd0, wd};
                            cur_addr_next = (temp_addr_reg & TEMP_HI_BYTE_MASK)
                                | {8'd0, wd};
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA:
                    begin
                        result.mem_addr       = cur_addr_reg;
                        result.mem_write      = 1'b1;
                        result.mem_write_data = wd;
                        cur_addr_next         = cur_addr_reg + step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_REG_READ:
            begin
                case (item.reg_index)
                    REG_CTRL1:
                    begin
                        result.read_data = control_one_reg;
                    end
                    REG_CTRL2:
                    begin
                        result.read_data = control_two_reg;
                    end
                    REG_STATUS:
                    begin
                        result.read_data                   = status_flags_reg;
                        status_flags_next[STAT_VBLANK_BIT] = 1'b0;
                        toggle_next                        = 1'b0;
                    end
                    REG_SCROLL:
                    begin
                        result.read_data = cur_addr_reg[7:0];
                    end
                    REG_ADDR:
                    begin
                        result.read_data = temp_addr_reg[7:0];
                    end
                    REG_DATA:
                    begin
                        result.read_data        = read_buf_reg;
                        result.mem_addr         = cur_addr_reg;
                        result.mem_read_request = 1'b1;
                        cur_addr_next           = cur_addr_reg + step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            MODE_MEM_RETURN:
            begin
                read_buf_next = item.mem_return_data;
            end
            default:
            begin
                case (item.event_code)
                    EVT_VBLANK_START:
                    begin
                        status_flags_next[STAT_VBLANK_BIT] = 1'b1;
                        result.interrupt_request = control_one_reg[CTRL1_NMI_BIT];
                    end
                    EVT_VBLANK_END:
                    begin
                        status_flags_next[STAT_VBLANK_BIT]   = 1'b0;
                        status_flags_next[STAT_HIT_BIT]      = 1'b0;
                        status_flags_next[STAT_OVERFLOW_BIT] = 1'b0;
                    end
                    EVT_SPRITE_HIT:
                    begin
                        status_flags_next[STAT_HIT_BIT] = 1'b1;
                    end
                    default:
                    begin
                        status_flags_next[STAT_OVERFLOW_BIT] = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_one_reg  <= '0;
            control_two_reg  <= '0;
            status_flags_reg <= '0;
            sprite_addr_reg  <= '0;
            temp_addr_reg    <= '0;
            cur_addr_reg     <= '0;
            fine_x_reg       <= '0;
            toggle_reg       <= 1'b0;
            read_buf_reg     <= '0;
        end
        else if (fire)
        begin
            control_one_reg  <= control_one_next;
            control_two_reg  <= control_two_next;
            status_flags_reg <= status_flags_next;
            sprite_addr_reg  <= sprite_addr_next;
            temp_addr_reg    <= temp_addr_next;
            cur_addr_reg     <= cur_addr_next;
            fine_x_reg       <= fine_x_next;
            toggle_reg       <= toggle_next;
            read_buf_reg     <= read_buf_next;
        end
    end

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> $onehot0({result.mem_write, result.mem_read_request,
                           result.sprite_mem_write, result.interrupt_request}))
        else $error("More than one request raised by a single transaction.");

    a_status_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_REG_READ && item.reg_index == REG_STATUS)
        |=> (!status_flags_reg[STAT_VBLANK_BIT] && !toggle_reg))
        else $error("Status read did not clear vblank and the write toggle.");

    a_addr_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_REG_WRITE && item.reg_index == REG_ADDR && toggle_reg)
        |=> (cur_addr_reg == temp_addr_reg))
        else $error("Second address write did not load the current address.");

    a_sprite_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_REG_WRITE && item.reg_index == REG_SPRITE_DATA)
        |=> (sprite_addr_reg == 8'($past(sprite_addr_reg) + 8'd1)))
        else $error("Sprite address did not advance after a sprite data write.");

endmodule

// ===== rtl/vcrp_out_reg.sv =====
module vcrp_out_reg
    import vcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  vcrp_result_t up_result,
    output logic         dn_valid,
    input  logic         dn_ready,
    output vcrp_result_t dn_result
);

    logic         valid_reg;
    vcrp_result_t result_reg;

    assign up_ready  = !valid_reg || dn_ready;
    assign dn_valid  = valid_reg;
    assign dn_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            result_reg <= up_result;
        end
    end

endmodule

// ===== rtl/video_chip_register_port.sv =====
// CPU register port of a tile video chip. One transaction is accepted on every clock
// while the result side keeps up. Each transaction passes through the input register
// and then the result register, with the register file updated in the cycle the
// transaction moves from one to the other. Every transaction yields exactly one result,
// so a stalled result side holds back the input side through the ready chain.
module video_chip_register_port
    import vcrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  mem_return_data,
    input  logic [1:0]  event_code,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic [15:0] mem_addr,
    output logic        mem_write,
    output logic [7:0]  mem_write_data,
    output logic        mem_read_request,
    output logic [7:0]  sprite_mem_addr,
    output logic [7:0]  sprite_mem_data,
    output logic        sprite_mem_write,
    output logic        interrupt_request
);

    vcrp_item_t   in_item;
    vcrp_item_t   work_item;
    logic         work_valid;
    logic         work_ready;
    vcrp_result_t work_result;
    vcrp_result_t out_result;

    assign in_item.mode            = vcrp_mode_t'(mode);
    assign in_item.reg_index       = vcrp_reg_t'(reg_index);
    assign in_item.write_data      = write_data;
    assign in_item.mem_return_data = mem_return_data;
    assign in_item.event_code      = vcrp_event_t'(event_code);

    vcrp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (item_valid),
        .up_ready (item_ready),
        .up_item  (in_item),
        .dn_valid (work_valid),
        .dn_ready (work_ready),
        .dn_item  (work_item)
    );

    vcrp_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (work_valid && work_ready),
        .item   (work_item),
        .result (work_result)
    );

    vcrp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (work_valid),
        .up_ready  (work_ready),
        .up_result (work_result),
        .dn_valid  (result_valid),
        .dn_ready  (result_ready),
        .dn_result (out_result)
    );

    assign read_data         = out_result.read_data;
    assign mem_addr          = out_result.mem_addr;
    assign mem_write         = out_result.mem_write;
    assign mem_write_data    = out_result.mem_write_data;
    assign mem_read_request  = out_result.mem_read_request;
    assign sprite_mem_addr   = out_result.sprite_mem_addr;
    assign sprite_mem_data   = out_result.sprite_mem_data;
    assign sprite_mem_write  = out_result.sprite_mem_write;
    assign interrupt_request = out_result.interrupt_request;

endmodule
